>>> rtl/core/rsc_pkg.sv
package rsc_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int CMD_W = 3;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W = 5;
   localparam int STEP_W = $clog2(DATA_W + 1);

   localparam logic [CNT_W-1:0] CNT_ZERO = CNT_W'(0);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   localparam logic [STEP_W-1:0] STEPS_SHORT = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEPS_LONG = STEP_W'(DATA_W);

   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SUB = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MUL = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DIV = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK = 3'd0,
      STATUS_UNDERFLOW = 3'd1,
      STATUS_DIV_ZERO = 3'd2,
      STATUS_FULL = 3'd3,
      STATUS_UNKNOWN = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EXEC,
      SEQ_REFILL,
      SEQ_RESP
   } seq_state_type;

   typedef struct packed {
      logic start;
      alu_op_type op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

>>> rtl/core/rsc_if.sv
interface rsc_req_if;
   logic valid;
   logic ready;
   logic [rsc_pkg::CMD_W-1:0] cmd;
   logic signed [rsc_pkg::DATA_W-1:0] push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface rsc_rsp_if;
   logic valid;
   logic ready;
   logic [rsc_pkg::STATUS_W-1:0] status;
   logic signed [rsc_pkg::DATA_W-1:0] top_value;
   logic [rsc_pkg::DEPTH_W-1:0] stack_depth;

   modport source (output valid, output status, output top_value, output stack_depth,
                   input ready);
   modport sink (input valid, input status, input top_value, input stack_depth,
                 output ready);
endinterface

>>> rtl/core/rsc_stack_mem.sv
module rsc_stack_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [rsc_pkg::PTR_W-1:0]    wr_addr,
   input  logic [rsc_pkg::DATA_W-1:0]   wr_data,
   input  logic [rsc_pkg::PTR_W-1:0]    rd_addr,
   output logic [rsc_pkg::DATA_W-1:0]   rd_data
);

   logic [rsc_pkg::DATA_W-1:0] mem_ff [rsc_pkg::STACK_DEPTH];
   logic [rsc_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/rsc_alu.sv
module rsc_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  rsc_pkg::alu_req_type  alu_req,
   output rsc_pkg::alu_rsp_type  alu_rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   rsc_pkg::alu_op_type op_ff, op_in;
   logic [rsc_pkg::STEP_W-1:0] step_ff, step_in;
   logic [rsc_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic [rsc_pkg::DATA_W-1:0] x_ff, x_in;
   logic [rsc_pkg::DATA_W-1:0] y_ff, y_in;
   logic neg_ff, neg_in;

   logic [rsc_pkg::DATA_W:0] add_x;
   logic [rsc_pkg::DATA_W:0] add_y;
   logic add_cin;
   logic [rsc_pkg::DATA_W:0] add_sum;
   logic [rsc_pkg::DATA_W-1:0] shifted_rem;
   logic sign_a;
   logic sign_b;

   assign shifted_rem = {acc_ff[rsc_pkg::DATA_W-2:0], y_ff[rsc_pkg::DATA_W-1]};
   assign add_sum = add_x + add_y + {{rsc_pkg::DATA_W{1'b0}}, add_cin};
   assign sign_a = alu_req.a[rsc_pkg::DATA_W-1];
   assign sign_b = alu_req.b[rsc_pkg::DATA_W-1];

   always_comb begin
      add_x = {1'b0, acc_ff};
      add_y = {1'b0, x_ff};
      add_cin = 1'b0;
      unique case (op_ff)
         rsc_pkg::ALU_ADD: begin
            add_y = {1'b0, x_ff};
         end
         rsc_pkg::ALU_SUB: begin
            add_y = {1'b0, ~x_ff};
            add_cin = 1'b1;
         end
         rsc_pkg::ALU_MUL: begin
            add_y = y_ff[0] ? {1'b0, x_ff} : '0;
         end
         rsc_pkg::ALU_DIV: begin
            add_x = {1'b0, shifted_rem};
            add_y = ~{1'b0, x_ff};
            add_cin = 1'b1;
         end
         default: begin
            add_y = {1'b0, x_ff};
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      y_in = y_ff;
      neg_in = neg_ff;
      if (alu_req.start) begin
         busy_in = 1'b1;
         op_in = alu_req.op;
         neg_in = sign_a ^ sign_b;
         if (alu_req.op == rsc_pkg::ALU_DIV) begin
            step_in = rsc_pkg::STEPS_LONG;
            acc_in = '0;
            x_in = sign_b ? (~alu_req.b + 1'b1) : alu_req.b;
            y_in = sign_a ? (~alu_req.a + 1'b1) : alu_req.a;
         end else if (alu_req.op == rsc_pkg::ALU_MUL) begin
            step_in = rsc_pkg::STEPS_LONG;
            acc_in = '0;
            x_in = alu_req.a;
            y_in = alu_req.b;
         end else begin
            step_in = rsc_pkg::STEPS_SHORT;
            acc_in = alu_req.a;
            x_in = alu_req.b;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            rsc_pkg::ALU_MUL: begin
               acc_in = add_sum[rsc_pkg::DATA_W-1:0];
               x_in = {x_ff[rsc_pkg::DATA_W-2:0], 1'b0};
               y_in = {1'b0, y_ff[rsc_pkg::DATA_W-1:1]};
            end
            rsc_pkg::ALU_DIV: begin
               acc_in = add_sum[rsc_pkg::DATA_W] ? shifted_rem
                                                 : add_sum[rsc_pkg::DATA_W-1:0];
               y_in = {y_ff[rsc_pkg::DATA_W-2:0], ~add_sum[rsc_pkg::DATA_W]};
            end
            default: begin
               acc_in = add_sum[rsc_pkg::DATA_W-1:0];
            end
         endcase
         step_in = step_ff - 1'b1;
         if (step_ff == rsc_pkg::STEPS_SHORT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff <= rsc_pkg::ALU_ADD;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff <= op_in;
      end
      step_ff <= step_in;
      acc_ff <= acc_in;
      x_ff <= x_in;
      y_ff <= y_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      alu_rsp.done = done_ff;
      if (op_ff == rsc_pkg::ALU_DIV) begin
         alu_rsp.result = neg_ff ? (~y_ff + 1'b1) : y_ff;
      end else begin
         alu_rsp.result = acc_ff;
      end
   end

endmodule

>>> rtl/core/rpn_stack_calculator_top.sv
// Clear, push and rejected commands go from IDLE straight to RESP; add, sub, mul and div
// go through READ and EXEC, a divide by zero through READ and, if entries remain, REFILL.
// One transaction at a time; mul and div run on the 32-step shift-add/subtract unit, and
// a new command is taken as soon as the previous one is finished.
// Reset (synchronous, active high) empties the stack and drops any pending result;
// stack contents are not cleared.
module rpn_stack_calculator_top (
   input logic clock,
   input logic reset,
   rsc_req_if.sink req_chan,
   rsc_rsp_if.source rsp_chan
);

   rsc_pkg::seq_state_type state_ff, state_in;
   logic [rsc_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   rsc_pkg::status_type status_ff, status_in;
   logic [rsc_pkg::CNT_W-1:0] count_ff, count_in;
   logic [rsc_pkg::DATA_W-1:0] top_ff, top_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rsc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [rsc_pkg::DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic [rsc_pkg::DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;

   logic mem_wr_en;
   logic [rsc_pkg::CNT_W-1:0] mem_wr_pos;
   logic [rsc_pkg::DATA_W-1:0] mem_wr_data;
   logic [rsc_pkg::CNT_W-1:0] mem_rd_pos;
   logic [rsc_pkg::DATA_W-1:0] mem_rd_data;
   logic [rsc_pkg::CNT_W-1:0] count_less_two;
   logic accept;

   rsc_pkg::alu_req_type alu_req;
   rsc_pkg::alu_rsp_type alu_rsp;

   assign count_less_two = count_ff - rsc_pkg::CNT_TWO;
   assign accept = req_chan.valid && req_chan.ready;

   rsc_stack_mem u_stack_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_pos[rsc_pkg::PTR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_pos[rsc_pkg::PTR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   rsc_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsc_pkg::SEQ_IDLE;
         count_ff <= rsc_pkg::CNT_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      status_ff <= status_in;
      top_ff <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff <= rsp_top_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      status_in = status_ff;
      count_in = count_ff;
      top_in = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in = rsp_top_ff;
      rsp_depth_in = rsp_depth_ff;
      mem_wr_en = 1'b0;
      mem_wr_pos = count_ff;
      mem_wr_data = req_chan.push_value;
      mem_rd_pos = count_less_two;
      alu_req.start = 1'b0;
      alu_req.op = rsc_pkg::ALU_ADD;
      alu_req.a = mem_rd_data;
      alu_req.b = top_ff;
      req_chan.ready = 1'b0;

      unique case (cmd_ff)
         rsc_pkg::CMD_SUB: alu_req.op = rsc_pkg::ALU_SUB;
         rsc_pkg::CMD_MUL: alu_req.op = rsc_pkg::ALU_MUL;
         rsc_pkg::CMD_DIV: alu_req.op = rsc_pkg::ALU_DIV;
         default: alu_req.op = rsc_pkg::ALU_ADD;
      endcase

      unique case (state_ff)
         rsc_pkg::SEQ_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               cmd_in = req_chan.cmd;
               status_in = rsc_pkg::STATUS_OK;
               state_in = rsc_pkg::SEQ_RESP;
               unique case (req_chan.cmd)
                  rsc_pkg::CMD_CLEAR: begin
                     count_in = rsc_pkg::CNT_ZERO;
                  end
                  rsc_pkg::CMD_PUSH: begin
                     if (count_ff >= rsc_pkg::CNT_FULL) begin
                        status_in = rsc_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        top_in = req_chan.push_value;
                        count_in = count_ff + rsc_pkg::CNT_ONE;
                     end
                  end
                  rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB, rsc_pkg::CMD_MUL,
                  rsc_pkg::CMD_DIV: begin
                     if (count_ff < rsc_pkg::CNT_TWO) begin
                        status_in = rsc_pkg::STATUS_UNDERFLOW;
                     end else begin
                        state_in = rsc_pkg::SEQ_READ;
                     end
                  end
                  default: begin
                     status_in = rsc_pkg::STATUS_UNKNOWN;
                  end
               endcase
            end
         end
         rsc_pkg::SEQ_READ: begin
            if (cmd_ff == rsc_pkg::CMD_DIV && top_ff == '0) begin
               status_in = rsc_pkg::STATUS_DIV_ZERO;
               count_in = count_less_two;
               mem_rd_pos = count_ff - rsc_pkg::CNT_THREE;
               if (count_ff > rsc_pkg::CNT_TWO) begin
                  state_in = rsc_pkg::SEQ_REFILL;
               end else begin
                  state_in = rsc_pkg::SEQ_RESP;
               end
            end else begin
               alu_req.start = 1'b1;
               state_in = rsc_pkg::SEQ_EXEC;
            end
         end
         rsc_pkg::SEQ_EXEC: begin
            if (alu_rsp.done) begin
               mem_wr_en = 1'b1;
               mem_wr_pos = count_less_two;
               mem_wr_data = alu_rsp.result;
               top_in = alu_rsp.result;
               count_in = count_ff - rsc_pkg::CNT_ONE;
               state_in = rsc_pkg::SEQ_RESP;
            end
         end
         rsc_pkg::SEQ_REFILL: begin
            top_in = mem_rd_data;
            state_in = rsc_pkg::SEQ_RESP;
         end
         rsc_pkg::SEQ_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_top_in = (count_ff == rsc_pkg::CNT_ZERO) ? '0 : top_ff;
               rsp_depth_in = rsc_pkg::DEPTH_W'(count_ff);
               state_in = rsc_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = rsc_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.top_value = rsp_top_ff;
   assign rsp_chan.stack_depth = rsp_depth_ff;

endmodule
